FILE: src/tpg_pkg.sv
package tpg_pkg;

  localparam int GRID_SIZE_DEF = 32;
  localparam int ROW_BITS_W    = 32;
  localparam int ROW_NUM_W     = 5;
  localparam int DIST_W        = 8;
  localparam int OP_W          = 3;

  typedef enum logic [OP_W-1:0] {
    OP_PEN_UP    = 3'd0,
    OP_PEN_DOWN  = 3'd1,
    OP_TURN_RIGHT = 3'd2,
    OP_TURN_LEFT = 3'd3,
    OP_MOVE      = 3'd4,
    OP_DUMP      = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    HEAD_RIGHT = 2'd0,
    HEAD_DOWN  = 2'd1,
    HEAD_LEFT  = 2'd2,
    HEAD_UP    = 2'd3
  } heading_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SWEEP = 2'd1,
    ST_DUMP  = 2'd2
  } state_t;

endpackage

FILE: src/turtle_pen_plotter_grid_top.sv
// Turtle plotter on a square bit grid held in a row memory (one 32-bit word per row, registered
// read). Pen up, pen down, turns, pen-up moves and unused codes leave the plotter idle. A
// pen-down move runs a read-modify-write sweep over the rows it touches: a horizontal move
// touches one row, a vertical move every row from its start row to its end row. A dump emits
// one row per beat from row 0, GRID_N beats (GRID_SIZE clamped to 2..32), at one beat per cycle
// when the result side does not stall; the next command waits until the last row has gone out. The
// sweep and the dump are paced by the single read port of the row memory. Per-row valid bits
// make the grid read as cleared right after reset, so there is no clearing pass.
module turtle_pen_plotter_grid_top #(
  parameter int GRID_SIZE = tpg_pkg::GRID_SIZE_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [tpg_pkg::OP_W-1:0]         in_operation,
  input  logic [tpg_pkg::DIST_W-1:0]       in_distance,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [tpg_pkg::ROW_BITS_W-1:0]   out_row_bits,
  output logic [tpg_pkg::ROW_NUM_W-1:0]    out_row_number,
  output logic                             out_last_row
);
  import tpg_pkg::*;

  localparam int GRID_N = (GRID_SIZE > ROW_BITS_W) ? ROW_BITS_W :
                          ((GRID_SIZE < 2) ? 2 : GRID_SIZE);
  localparam int ROW_W  = $clog2(GRID_N);
  localparam int SUM_W  = DIST_W + 1;

  localparam logic [ROW_W-1:0]      LAST_IDX = ROW_W'(GRID_N - 1);
  localparam logic [ROW_BITS_W-1:0] ALL_ONES = {ROW_BITS_W{1'b1}};

  state_t state_r, state_nxt;

  logic             pen_r, pen_nxt;
  heading_t         head_r, head_nxt;
  logic [ROW_W-1:0] cur_row_r, cur_row_nxt;
  logic [ROW_W-1:0] cur_col_r, cur_col_nxt;

  logic [ROW_W-1:0]      ptr_r, ptr_nxt;
  logic [ROW_W-1:0]      hi_r, hi_nxt;
  logic [ROW_BITS_W-1:0] mask_r, mask_nxt;
  logic                  issued_all_r, issued_all_nxt;

  logic [ROW_BITS_W-1:0] grid_mem [GRID_N];
  logic [GRID_N-1:0]     row_vld_r;
  logic [ROW_BITS_W-1:0] rd_q_r;
  logic                  rd_ok_r;
  logic [ROW_W-1:0]      rd_addr_r;
  logic                  rd_pend_r, rd_pend_nxt;

  logic                  out_valid_r;
  logic [ROW_BITS_W-1:0] out_row_bits_r;
  logic [ROW_NUM_W-1:0]  out_row_number_r;
  logic                  out_last_row_r;

  logic                  in_acc;
  logic                  issue_en;
  logic                  sweep_wr;
  logic                  move_out;
  logic [ROW_BITS_W-1:0] rd_row;

  // move decode
  logic                  vertical;
  logic                  forward;
  logic [ROW_W-1:0]      from_pos;
  logic [ROW_W-1:0]      to_pos;
  logic [SUM_W-1:0]      fwd_sum;
  logic [ROW_W-1:0]      lo_pos;
  logic [ROW_W-1:0]      hi_pos;
  logic [ROW_BITS_W-1:0] col_mask;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign rd_row   = rd_ok_r ? rd_q_r : '0;

  always_comb begin
    vertical = head_r[0];
    forward  = (head_r == HEAD_RIGHT) || (head_r == HEAD_DOWN);
    from_pos = vertical ? cur_row_r : cur_col_r;
    fwd_sum  = SUM_W'(from_pos) + SUM_W'(in_distance);
    if (forward) begin
      to_pos = (fwd_sum > SUM_W'(GRID_N - 1)) ? LAST_IDX : ROW_W'(fwd_sum);
    end else begin
      to_pos = (in_distance > DIST_W'(from_pos)) ? '0
             : ROW_W'(DIST_W'(from_pos) - in_distance);
    end
    lo_pos   = forward ? from_pos : to_pos;
    hi_pos   = forward ? to_pos : from_pos;
    col_mask = (ALL_ONES << lo_pos)
             & (ALL_ONES >> (ROW_NUM_W'(ROW_BITS_W - 1) - ROW_NUM_W'(hi_pos)));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_operation == OP_DUMP) begin
            state_nxt = ST_DUMP;
          end else if (in_operation == OP_MOVE && pen_r) begin
            state_nxt = ST_SWEEP;
          end
        end
      end
      ST_SWEEP: begin
        if (issued_all_r && (!rd_pend_r || sweep_wr)) state_nxt = ST_IDLE;
      end
      ST_DUMP: begin
        if (issued_all_r && (!rd_pend_r || move_out)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    issue_en = 1'b0;
    sweep_wr = 1'b0;
    move_out = 1'b0;
    unique case (state_r)
      ST_IDLE: ;
      ST_SWEEP: begin
        issue_en = !issued_all_r;
        sweep_wr = rd_pend_r;
      end
      ST_DUMP: begin
        move_out = rd_pend_r && (!out_valid_r || !out_stall);
        issue_en = !issued_all_r && (!rd_pend_r || move_out);
      end
      default: ;
    endcase
  end

  always_comb begin
    pen_nxt        = pen_r;
    head_nxt       = head_r;
    cur_row_nxt    = cur_row_r;
    cur_col_nxt    = cur_col_r;
    ptr_nxt        = ptr_r;
    hi_nxt         = hi_r;
    mask_nxt       = mask_r;
    issued_all_nxt = issued_all_r;
    if (in_acc) begin
      unique case (in_operation)
        OP_PEN_UP:     pen_nxt = 1'b0;
        OP_PEN_DOWN:   pen_nxt = 1'b1;
        OP_TURN_RIGHT: head_nxt = heading_t'(head_r + 2'd1);
        OP_TURN_LEFT:  head_nxt = heading_t'(head_r - 2'd1);
        OP_MOVE: begin
          // only a pen-down move starts a sweep
          issued_all_nxt = !pen_r;
          if (vertical) begin
            cur_row_nxt = to_pos;
            ptr_nxt     = lo_pos;
            hi_nxt      = hi_pos;
            mask_nxt    = ROW_BITS_W'(1) << cur_col_r;
          end else begin
            cur_col_nxt = to_pos;
            ptr_nxt     = cur_row_r;
            hi_nxt      = cur_row_r;
            mask_nxt    = col_mask;
          end
        end
        OP_DUMP: begin
          issued_all_nxt = 1'b0;
          ptr_nxt        = '0;
          hi_nxt         = LAST_IDX;
        end
        default: ;
      endcase
    end else if (issue_en) begin
      if (ptr_r == hi_r) begin
        issued_all_nxt = 1'b1;
      end else begin
        ptr_nxt = ptr_r + 1'b1;
      end
    end
  end

  always_comb begin
    rd_pend_nxt = rd_pend_r;
    if (issue_en) begin
      rd_pend_nxt = 1'b1;
    end else if (sweep_wr || move_out) begin
      rd_pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pen_r        <= 1'b0;
      head_r       <= HEAD_RIGHT;
      cur_row_r    <= '0;
      cur_col_r    <= '0;
      issued_all_r <= 1'b1;
      rd_pend_r    <= 1'b0;
      row_vld_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pen_r        <= pen_nxt;
      head_r       <= head_nxt;
      cur_row_r    <= cur_row_nxt;
      cur_col_r    <= cur_col_nxt;
      issued_all_r <= issued_all_nxt;
      rd_pend_r    <= rd_pend_nxt;
      if (sweep_wr) row_vld_r[rd_addr_r] <= 1'b1;
      if (move_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r  <= ptr_nxt;
    hi_r   <= hi_nxt;
    mask_r <= mask_nxt;
  end

  // row memory: one read and one write port; the sweep writes row i while reading row i + 1
  always_ff @(posedge clk) begin
    if (sweep_wr) grid_mem[rd_addr_r] <= rd_row | mask_r;
    if (issue_en) begin
      rd_q_r    <= grid_mem[ptr_r];
      rd_ok_r   <= row_vld_r[ptr_r];
      rd_addr_r <= ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (move_out) begin
      out_row_bits_r   <= rd_row;
      out_row_number_r <= ROW_NUM_W'(rd_addr_r);
      out_last_row_r   <= (rd_addr_r == LAST_IDX);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_row_bits   = out_row_bits_r;
  assign out_row_number = out_row_number_r;
  assign out_last_row   = out_last_row_r;

`ifndef ASSERT_OFF
  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!rd_pend_r && issued_all_r))
    else $error("command taken with row access still in flight");

  a_last_row_num: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_row_r) |-> (out_row_number_r == ROW_NUM_W'(GRID_N - 1)))
    else $error("last row flag on wrong row number");

  a_pos_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_row_r <= LAST_IDX) && (cur_col_r <= LAST_IDX))
    else $error("turtle position outside the grid");

  a_write_only_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    sweep_wr |-> $past(issue_en))
    else $error("row write without a preceding read");
`endif

endmodule
